// ===== hdl/lcgj_pkg.sv =====
// Shared types, constants and helpers for the 128-bit LCG step unit.
`default_nettype none
package lcgj_pkg;

  localparam logic [127:0] LcgMult = 128'hdb36357734e34abb0050d0761fcdfc15;
  localparam logic [127:0] LcgAdd  = 128'h7;
  localparam logic [127:0] LcgMinv = 128'd295713064423480201165222953644432290621;

  // Limb products of a 128x128 product kept below 2^128, in issue order.
  localparam int unsigned NumParts = 10;

  typedef enum logic [1:0] {
    MODE_FWD  = 2'd0,
    MODE_INV  = 2'd1,
    MODE_SKIP = 2'd2,
    MODE_PASS = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE, S_FWD, S_INV, S_BIT, S_MN, S_CN, S_CC, S_MM, S_FIN, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    SEL_FWD, SEL_INV, SEL_MN, SEL_CN, SEL_CC, SEL_MM, SEL_FIN
  } sel_e;

  typedef struct packed {
    logic load;
    logic mul_start;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic n_bit;
    logic n_zero;
  } stat_t;

  // Limb indexes (i of a, j of b) of partial product k.
  function automatic logic [3:0] part_idx(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0:    r = {2'd0, 2'd0};
      4'd1:    r = {2'd0, 2'd1};
      4'd2:    r = {2'd1, 2'd0};
      4'd3:    r = {2'd0, 2'd2};
      4'd4:    r = {2'd1, 2'd1};
      4'd5:    r = {2'd2, 2'd0};
      4'd6:    r = {2'd0, 2'd3};
      4'd7:    r = {2'd1, 2'd2};
      4'd8:    r = {2'd2, 2'd1};
      4'd9:    r = {2'd3, 2'd0};
      default: r = {2'd0, 2'd0};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lcgj_mul.sv =====
// Iterative 128x128 multiplier modulo 2^128 on one 32x32 multiplier.
`default_nettype none
module lcgj_mul import lcgj_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] a_i,
  input  wire logic [127:0] b_i,
  output logic              done_o,
  output logic [127:0]      p_o
);

  logic [127:0] a_q, b_q, acc_q, acc_d;
  logic [3:0]   cnt_q;
  logic         run_q, pv_q, plast_q, done_q;
  logic [63:0]  prod_q;
  logic [1:0]   sh_q;
  logic [3:0]   idx;
  logic [1:0]   ia, ib;
  logic [31:0]  la, lb;

  // Select the limbs of the current partial product
  always_comb begin
    idx = part_idx(cnt_q);
    ia  = idx[3:2];
    ib  = idx[1:0];
    la  = a_q[{ia, 5'd0} +: 32];
    lb  = b_q[{ib, 5'd0} +: 32];
  end

  // Shift the registered product into place and accumulate
  always_comb begin
    acc_d = acc_q + ({64'd0, prod_q} << {sh_q, 5'd0});
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      plast_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      pv_q    <= run_q;
      plast_q <= run_q && (cnt_q == 4'(NumParts - 1));
      done_q  <= pv_q && plast_q;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == 4'(NumParts - 1)) begin
          run_q <= 1'b0;
        end
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  // Operands, product register and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_d;
    end
    prod_q <= la * lb;
    sh_q   <= ia + ib;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
`default_nettype wire

// ===== hdl/lcgj_dp.sv =====
// Datapath: jump-ahead registers, operand select and write-back.
`default_nettype none
module lcgj_dp import lcgj_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cmd_t         cmd_i,
  output stat_t             stat_o,
  input  wire logic [127:0] seed_i,
  input  wire logic [127:0] steps_i,
  output logic [127:0]      res_o
);

  logic [127:0] seed_q, n_q, mm_q, cc_q, mn_q, cn_q, res_q;
  logic [127:0] op_a, op_b, prod;
  logic         done;

  // Pick multiplier operands for the current operation
  always_comb begin
    case (cmd_i.sel)
      SEL_FWD: begin op_a = LcgMult;         op_b = seed_q;  end
      SEL_INV: begin op_a = seed_q - LcgAdd; op_b = LcgMinv; end
      SEL_MN:  begin op_a = mn_q;            op_b = mm_q;    end
      SEL_CN:  begin op_a = cn_q;            op_b = mm_q;    end
      SEL_CC:  begin op_a = mm_q + 128'd1;   op_b = cc_q;    end
      SEL_MM:  begin op_a = mm_q;            op_b = mm_q;    end
      SEL_FIN: begin op_a = mn_q;            op_b = seed_q;  end
      default: begin op_a = mn_q;            op_b = seed_q;  end
    endcase
  end

  lcgj_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (done),
    .p_o     (prod)
  );

  // Load a transaction, then write back each finished product
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      seed_q <= seed_i;
      n_q    <= steps_i;
      mm_q   <= LcgMult;
      cc_q   <= LcgAdd;
      mn_q   <= 128'd1;
      cn_q   <= '0;
      res_q  <= seed_i;
    end else if (done) begin
      case (cmd_i.sel)
        SEL_FWD: res_q <= prod + LcgAdd;
        SEL_INV: res_q <= prod;
        SEL_MN:  mn_q  <= prod;
        SEL_CN:  cn_q  <= prod + cc_q;
        SEL_CC:  cc_q  <= prod;
        SEL_MM: begin
          mm_q <= prod;
          n_q  <= n_q >> 1;
        end
        SEL_FIN: res_q <= prod + cn_q;
        default: res_q <= res_q;
      endcase
    end
  end

  assign stat_o.mul_done = done;
  assign stat_o.n_bit    = n_q[0];
  assign stat_o.n_zero   = (n_q == '0);
  assign res_o           = res_q;

endmodule
`default_nettype wire

// ===== hdl/lcgj_ctrl.sv =====
// Controller: sequences the multiplies of step, inverse and jump-ahead.
`default_nettype none
module lcgj_ctrl import lcgj_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [1:0] mode_i,
  input  wire stat_t      stat_i,
  output cmd_t            cmd_o,
  output logic            busy,
  output logic            result_valid_o
);

  state_e state_q, state_d;
  logic   issued_q, issued_d;
  logic   mul_state;

  assign mul_state = (state_q == S_FWD) || (state_q == S_INV) || (state_q == S_MN) ||
                     (state_q == S_CN) || (state_q == S_CC) || (state_q == S_MM) ||
                     (state_q == S_FIN);

  // Next state
  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    if (mul_state) begin
      if (!issued_q) begin
        issued_d = 1'b1;
      end else if (stat_i.mul_done) begin
        issued_d = 1'b0;
      end
    end
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (mode_e'(mode_i))
            MODE_FWD:  state_d = S_FWD;
            MODE_INV:  state_d = S_INV;
            MODE_SKIP: state_d = S_BIT;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_BIT: begin
        if (stat_i.n_zero) begin
          state_d = S_FIN;
        end else if (stat_i.n_bit) begin
          state_d = S_MN;
        end else begin
          state_d = S_CC;
        end
      end
      S_FWD, S_INV, S_FIN: if (issued_q && stat_i.mul_done) state_d = S_DONE;
      S_MN: if (issued_q && stat_i.mul_done) state_d = S_CN;
      S_CN: if (issued_q && stat_i.mul_done) state_d = S_CC;
      S_CC: if (issued_q && stat_i.mul_done) state_d = S_MM;
      S_MM: if (issued_q && stat_i.mul_done) state_d = S_BIT;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.load      = (state_q == S_IDLE) && start;
    cmd_o.mul_start = mul_state && !issued_q;
    case (state_q)
      S_FWD:   cmd_o.sel = SEL_FWD;
      S_INV:   cmd_o.sel = SEL_INV;
      S_MN:    cmd_o.sel = SEL_MN;
      S_CN:    cmd_o.sel = SEL_CN;
      S_CC:    cmd_o.sel = SEL_CC;
      S_MM:    cmd_o.sel = SEL_MM;
      default: cmd_o.sel = SEL_FIN;
    endcase
    busy           = (state_q != S_IDLE);
    result_valid_o = (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lcg128_step_inverse_skip.sv =====
// Each multiply runs on the shared 32x32 multiplier (10 limb products).
// Forward and inverse steps each use one multiply; a pass-through uses none.
// Skip uses four multiplies per set count bit, two per clear one, up to the top set bit,
// then a final one; one transaction at a time, busy stays high until the result strobe.
// Reset (async, active low) returns the controller to idle; the receiver cannot stall.
`default_nettype none
module lcg128_step_inverse_skip import lcgj_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode_i,
  input  wire logic [63:0] seed_lo_i,
  input  wire logic [63:0] seed_hi_i,
  input  wire logic [63:0] steps_lo_i,
  input  wire logic signed [63:0] steps_hi_i,
  output logic             result_valid_o,
  output logic [63:0]      result_lo_o,
  output logic [63:0]      result_hi_o
);

  cmd_t         cmd;
  stat_t        stat;
  logic [127:0] res;

  lcgj_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .mode_i         (mode_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  lcgj_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .seed_i  ({seed_hi_i, seed_lo_i}),
    .steps_i ({steps_hi_i, steps_lo_i}),
    .res_o   (res)
  );

  assign result_lo_o = res[63:0];
  assign result_hi_o = res[127:64];

endmodule
`default_nettype wire
